### src/rde_pkg.sv
// shared constants and digit helpers for the radix digit emitter
package rde_pkg;

  localparam int BASE_W  = 6;
  localparam int DIGIT_W = 6;
  localparam int CHAR_W  = 7;
  localparam int COUNT_W = 6;

  localparam logic [BASE_W-1:0] BASE_MIN = 6'd2;
  localparam logic [BASE_W-1:0] BASE_MAX = 6'd36;

  localparam logic [DIGIT_W-1:0] DEC_DIGITS = 6'd10;
  localparam logic [CHAR_W-1:0]  CHAR_ZERO  = 7'd48;
  localparam logic [CHAR_W-1:0]  CHAR_ALPHA = 7'd55;

  typedef logic [BASE_W-1:0]  base_t;
  typedef logic [DIGIT_W-1:0] digit_t;
  typedef logic [CHAR_W-1:0]  char_t;
  typedef logic [COUNT_W-1:0] count_t;

  function automatic base_t clamp_base(input base_t b);
    base_t r;
    if (b < BASE_MIN) begin
      r = BASE_MIN;
    end else if (b > BASE_MAX) begin
      r = BASE_MAX;
    end else begin
      r = b;
    end
    return r;
  endfunction

  function automatic char_t digit_to_char(input digit_t d);
    char_t r;
    if (d < DEC_DIGITS) begin
      r = CHAR_ZERO + {1'b0, d};
    end else begin
      r = CHAR_ALPHA + {1'b0, d};
    end
    return r;
  endfunction

endpackage

### src/rde_divider.sv
// bit-serial restoring divider, one quotient bit per cycle
module rde_divider #(
  parameter int W = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 load,
  input  logic [W-1:0]         dividend,
  input  rde_pkg::base_t       divisor,
  output logic [W-1:0]         quotient,
  output rde_pkg::digit_t      remainder,
  output logic                 done
);
  import rde_pkg::*;

  localparam int CNT_W = $clog2(W);

  logic [W-1:0]       quo;
  digit_t             rem;
  logic [CNT_W-1:0]   cnt;
  logic               run;
  logic [DIGIT_W:0]   trial;
  logic               ge;
  digit_t             rem_next;

  always_comb begin
    trial    = {rem, quo[W-1]};
    ge       = trial >= {1'b0, divisor};
    rem_next = ge ? DIGIT_W'(trial - {1'b0, divisor}) : trial[DIGIT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (load) begin
        run <= 1'b1;
      end else if (run && cnt == CNT_W'(W - 1)) begin
        run  <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      quo <= dividend;
      rem <= '0;
      cnt <= '0;
    end else if (run) begin
      quo <= {quo[W-2:0], ge};
      rem <= rem_next;
      cnt <= cnt + 1'b1;
    end
  end

  assign quotient  = quo;
  assign remainder = rem;

endmodule

### src/rde_digit_buf.sv
// digit store, filled low digit first and read back high digit first
module rde_digit_buf #(
  parameter int DEPTH = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 clear,
  input  logic                 push,
  input  logic                 finish,
  input  rde_pkg::digit_t      push_digit,
  output logic                 strobe,
  output rde_pkg::char_t       digit_char,
  output rde_pkg::count_t      digit_count,
  output logic                 last_digit,
  output logic                 busy
);
  import rde_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  digit_t           mem [DEPTH];
  logic [CW-1:0]    wr_ptr;
  logic [CW-1:0]    count;
  logic [AW-1:0]    rd_ptr;
  logic             reading;
  logic             rd_vld;
  logic             rd_last;
  digit_t           rd_data;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr[AW-1:0]] <= push_digit;
    end
    if (reading) begin
      rd_data <= mem[rd_ptr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr  <= '0;
      reading <= 1'b0;
      rd_vld  <= 1'b0;
      rd_last <= 1'b0;
    end else begin
      rd_vld  <= reading;
      rd_last <= reading && rd_ptr == '0;
      if (clear) begin
        wr_ptr <= '0;
      end else if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (push && finish) begin
        reading <= 1'b1;
        rd_ptr  <= wr_ptr[AW-1:0];
        count   <= wr_ptr + 1'b1;
      end else if (reading) begin
        if (rd_ptr == '0) begin
          reading <= 1'b0;
        end else begin
          rd_ptr <= rd_ptr - 1'b1;
        end
      end
    end
  end

  assign strobe      = rd_vld;
  assign digit_char  = digit_to_char(rd_data);
  assign digit_count = COUNT_W'(count);
  assign last_digit  = rd_last;
  assign busy        = reading || rd_vld;

endmodule

### src/radix_digit_emitter_unit.sv
// top level: integer to radix digit string converter
//
// Converts one unsigned value to its digits in a base from 2 to 36 (bases
// outside that range saturate to it) and emits them most significant
// first, one beat per digit on strobe, as ASCII '0'-'9' then 'A'-'Z', each
// beat carrying the total digit count and the final one marked by
// last_digit. A zero value gives the single digit '0'. The receiver cannot
// stall: digits of one value come on consecutive cycles. Each digit comes
// from a bit-serial divide by the base, then the digits are read back
// out one per cycle; start is taken again once busy falls.
module radix_digit_emitter_unit #(
  parameter int VALUE_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic [VALUE_BITS-1:0] value,
  input  rde_pkg::base_t        base,
  output logic                  strobe,
  output rde_pkg::char_t        digit_char,
  output rde_pkg::count_t       digit_count,
  output logic                  last_digit
);
  import rde_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_DIV  = 1'b1;

  logic                  state;
  logic                  state_next;
  base_t                 base_reg;
  logic                  accept;
  logic                  div_load;
  logic [VALUE_BITS-1:0] div_dividend;
  logic [VALUE_BITS-1:0] div_quo;
  digit_t                div_rem;
  logic                  div_done;
  logic                  quo_zero;
  logic                  buf_busy;

  assign busy     = state != ST_IDLE || buf_busy;
  assign accept   = start && !busy;
  assign quo_zero = div_quo == '0;

  always_comb begin
    state_next   = state;
    div_load     = 1'b0;
    div_dividend = div_quo;
    unique case (state)
      ST_IDLE: begin
        div_dividend = value;
        if (accept) begin
          div_load   = 1'b1;
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          if (quo_zero) begin
            state_next = ST_IDLE;
          end else begin
            div_load = 1'b1;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      base_reg <= clamp_base(base);
    end
  end

  rde_divider #(
    .W (VALUE_BITS)
  ) u_divider (
    .clk       (clk),
    .rst       (rst),
    .load      (div_load),
    .dividend  (div_dividend),
    .divisor   (base_reg),
    .quotient  (div_quo),
    .remainder (div_rem),
    .done      (div_done)
  );

  rde_digit_buf #(
    .DEPTH (VALUE_BITS)
  ) u_digit_buf (
    .clk         (clk),
    .rst         (rst),
    .clear       (accept),
    .push        (state == ST_DIV && div_done),
    .finish      (quo_zero),
    .push_digit  (div_rem),
    .strobe      (strobe),
    .digit_char  (digit_char),
    .digit_count (digit_count),
    .last_digit  (last_digit),
    .busy        (buf_busy)
  );

endmodule

### verif/tb_top.sv
`timescale 1ns / 1ps
// testbench for radix_digit_emitter_unit: directed and random conversions checked digit by digit
module tb_top;
  import rde_pkg::*;

  localparam int VBITS = 32;
  localparam int TAIL_CYCLES = 40;

  typedef struct {
    logic [VBITS-1:0] value;
    base_t            base;
    int unsigned      gap;
  } conv_item_t;

  typedef struct {
    char_t  ch;
    count_t cnt;
    logic   last;
  } digit_beat_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             start = 1'b0;
  logic             busy;
  logic [VBITS-1:0] value = '0;
  base_t            base = '0;
  logic             strobe;
  char_t            digit_char;
  count_t           digit_count;
  logic             last_digit;

  conv_item_t  pending_items[$];
  conv_item_t  next_item;
  digit_beat_t expected_digits[$];
  digit_beat_t want;
  logic        item_loaded = 1'b0;
  int unsigned gap_left = 0;
  int          n_items = 0;
  int          n_accepted = 0;
  int          n_beats = 0;
  int          n_errors = 0;
  int          longest = 0;
  logic [36:0] bases_seen = '0;

  radix_digit_emitter_unit #(.VALUE_BITS(VBITS)) u_dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .value       (value),
    .base        (base),
    .strobe      (strobe),
    .digit_char  (digit_char),
    .digit_count (digit_count),
    .last_digit  (last_digit)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  task automatic report_mismatch(input string what);
    n_errors++;
    if (n_errors <= 50) begin
      $display("mismatch at %0t: %s", $time, what);
    end
  endtask

  function automatic void predict_digits(input logic [VBITS-1:0] v, input base_t b);
    logic [VBITS-1:0] rem;
    int unsigned      radix;
    digit_t           rev[$];
    digit_t           d;
    digit_beat_t      beat;
    int               n;
    radix = 32'((b < BASE_MIN) ? BASE_MIN : (b > BASE_MAX) ? BASE_MAX : b);
    bases_seen[radix] = 1'b1;
    rem = v;
    do begin
      rev.push_back(digit_t'(rem % radix));
      rem = rem / radix;
    end while (rem != 0);
    n = rev.size();
    if (n > longest) longest = n;
    for (int k = n - 1; k >= 0; k--) begin
      d = rev[k];
      beat.ch   = (d < 10) ? char_t'("0" + d) : char_t'("A" + d - 10);
      beat.cnt  = count_t'(n);
      beat.last = (k == 0);
      expected_digits.push_back(beat);
    end
  endfunction

  // driver: start stays up until the beat is taken
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        predict_digits(value, base);
        n_accepted++;
      end
      if (!start || !busy) begin
        if (!item_loaded && pending_items.size() != 0) begin
          next_item = pending_items.pop_front();
          gap_left = next_item.gap;
          item_loaded = 1'b1;
        end
        if (item_loaded && gap_left == 0) begin
          value <= next_item.value;
          base <= next_item.base;
          start <= 1'b1;
          item_loaded = 1'b0;
        end else begin
          start <= 1'b0;
          if (item_loaded) gap_left--;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst && strobe) begin
      if (expected_digits.size() == 0) begin
        report_mismatch($sformatf("digit 0x%0h with nothing pending", digit_char));
      end else begin
        want = expected_digits.pop_front();
        n_beats++;
        if (digit_char !== want.ch)
          report_mismatch($sformatf("digit_char 0x%0h, want 0x%0h", digit_char, want.ch));
        if (digit_count !== want.cnt)
          report_mismatch($sformatf("digit_count %0d, want %0d", digit_count, want.cnt));
        if (last_digit !== want.last)
          report_mismatch($sformatf("last_digit %0b, want %0b", last_digit, want.last));
      end
    end
  end

  function automatic int unsigned pick_gap(input int idx);
    return ((idx / 40) % 3 == 0) ? 0 : $urandom_range(0, 19);
  endfunction

  function automatic void add_item(input logic [VBITS-1:0] v, input base_t b, input int idx);
    conv_item_t it;
    it.value = v;
    it.base  = b;
    it.gap   = pick_gap(idx);
    pending_items.push_back(it);
  endfunction

  initial begin
    logic [63:0]      p;
    logic [VBITS-1:0] v;
    int unsigned      radix;
    base_t            b;
    int               k;

    // directed: zero, full scale, saturated bases, digit boundaries
    add_item(32'd0, 6'd10, 1);
    add_item(32'd0, 6'd2, 1);
    add_item(32'd0, 6'd0, 1);
    add_item(32'hFFFF_FFFF, 6'd2, 1);
    add_item(32'hFFFF_FFFF, 6'd36, 1);
    add_item(32'hFFFF_FFFF, 6'd16, 1);
    add_item(32'hFFFF_FFFF, 6'd10, 1);
    add_item(32'hFFFF_FFFF, 6'd8, 1);
    add_item(32'h8000_0000, 6'd2, 1);
    add_item(32'h7FFF_FFFF, 6'd3, 1);
    add_item(32'd1, 6'd2, 1);
    add_item(32'd9, 6'd10, 1);
    add_item(32'd10, 6'd11, 1);
    add_item(32'd35, 6'd36, 1);
    add_item(32'd36, 6'd36, 1);
    add_item(32'd1295, 6'd36, 1);
    add_item(32'd5, 6'd0, 1);
    add_item(32'd5, 6'd1, 1);
    add_item(32'hDEAD_BEEF, 6'd37, 1);
    add_item(32'hFFFF_FFFF, 6'd63, 1);
    add_item(32'h5555_5555, 6'd63, 1);
    add_item(32'd0, 6'd63, 1);

    for (int i = 0; i < 440; i++) begin
      radix = $urandom_range(2, 36);
      b = base_t'(radix);
      if (radix == 2 && $urandom_range(0, 3) == 0) b = base_t'($urandom_range(0, 1));
      if (radix == 36 && $urandom_range(0, 3) == 0) b = base_t'($urandom_range(37, 63));
      case ($urandom_range(0, 4))
        0: v = $urandom;
        1: v = $urandom_range(0, 255);
        2: begin
          p = 1;
          k = $urandom_range(1, 31);
          repeat (k) if (p * radix <= 64'hFFFF_FFFF) p = p * radix;
          v = VBITS'(p - $urandom_range(0, 1));
        end
        3: v = {1'b1, (VBITS-1)'($urandom)};
        default: v = $urandom_range(0, 65535);
      endcase
      if ($urandom_range(0, 30) == 0) v = '0;
      add_item(v, b, i);
    end
    n_items = pending_items.size();

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    while (n_accepted < n_items) @(posedge clk);
    while (expected_digits.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("converted %0d values in %0d of 35 bases, %0d digits checked, longest %0d digits",
             n_accepted, $countones(bases_seen), n_beats, longest);
    if (n_errors == 0) begin
      $display("[radix_digit_emitter_unit] OK");
    end else begin
      $display("%0d mismatches", n_errors);
      $display("[radix_digit_emitter_unit] ERROR");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("timeout: %0d of %0d values taken, %0d digits pending",
             n_accepted, n_items, expected_digits.size());
    $display("[radix_digit_emitter_unit] ERROR");
    $finish;
  end

endmodule
